@@ rtl/tc6rx_pkg.sv @@
// Package for the receive chunk deframer: sizes, footer bit positions,
// status codes and the descriptor that passes from the front end to the back end.
// No dependencies.
`default_nettype none
package tc6rx_pkg;

	localparam int CHUNK_BYTES     = 64;
	localparam int MAX_FRAME_LIMIT = 2048;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 12;
	localparam int CFG_W   = 12;
	localparam int CHUNK_W = $clog2(CHUNK_BYTES);
	localparam int CNT_W   = $clog2(CHUNK_BYTES + 1);
	localparam int POS_W   = $clog2(CHUNK_BYTES + 4);
	localparam int LIM_W   = $clog2(MAX_FRAME_LIMIT + 1);
	localparam int CMP_W   = ((LEN_W > LIM_W) ? LEN_W : LIM_W) + 1;
	localparam int ADDR_W  = CHUNK_W + 1;
	localparam int BUF_DEPTH = 2 ** ADDR_W;

	localparam int FOOTER_W = 32;
	localparam int EBO_W    = 6;
	localparam int FTR_DV   = 21;
	localparam int FTR_SV   = 20;
	localparam int FTR_EV   = 14;
	localparam int FTR_EBO  = 8;

	localparam logic [CFG_W-1:0] MAX_FRAME_RESET = CFG_W'(1536);

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_START = 2'd2,
		ST_OVER  = 2'd3
	} status_t;

	// one classified chunk
	typedef struct packed {
		status_t            status;
		logic               bank;
		logic [CHUNK_W-1:0] last_idx;
		logic               first;
		logic               ev;
		logic [LEN_W-1:0]   total;
	} desc_t;

	// back end hands a drained buffer bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

endpackage
`default_nettype wire

@@ rtl/tc6_rx_chunk_deframer_unit.sv @@
// Top level of the receive chunk deframer: configuration register and the
// wiring of front end, descriptor queue, payload buffer and back end. Depends on tc6rx_pkg.
//
// Use:
//   Input channel (in_valid / in_stall): one link byte per transaction,
//   rx_byte with chunk_first marking payload byte 0 of a chunk. A chunk is
//   CHUNK_BYTES payload bytes then a 4-byte big-endian footer.
//   Output channel (out_valid / out_stall): one result per transaction.
//   A good chunk gives EBO+1 bytes (end of frame) or the full payload; a
//   rejected chunk gives one status-only result with last_of_chunk set.
//   Configuration: max_frame_bytes is written on cfg_valid && cfg_ready;
//   cfg_ready is always high. Write only while idle.
// Timing:
//   Input takes one byte per cycle unless stalled. The last footer byte pushes a
//   chunk descriptor into the queue register; the output register then gives its
//   results, one per cycle unless out_stall holds. Payload sits in two buffer
//   banks, so one chunk drains while the next fills; the input stalls only when both
//   banks are held or the two-entry descriptor queue is full (receiver stalling for long).
// Reset:
//   arst_n clears position, footer, frame state, queue and output valid;
//   max_frame_bytes returns to 1536. Buffer contents are not cleared.
//   An output transaction stalled by out_stall holds its payload.
`default_nettype none
module tc6_rx_chunk_deframer_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [tc6rx_pkg::BYTE_W-1:0]  rx_byte,
	input  wire logic                          chunk_first,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [tc6rx_pkg::BYTE_W-1:0]  data_byte,
	output logic                               frame_start,
	output logic                               frame_end,
	output logic      [1:0]                    status,
	output logic      [tc6rx_pkg::LEN_W-1:0]   frame_length,
	output logic                               last_of_chunk,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tc6rx_pkg::CFG_W-1:0]   max_frame_bytes
);

	logic [tc6rx_pkg::CFG_W-1:0]  max_frame_q;

	logic                         q_full, q_empty, push, pop;
	tc6rx_pkg::desc_t             push_desc, head;
	tc6rx_pkg::release_t          rel;
	logic                         buf_we, buf_re;
	logic [tc6rx_pkg::ADDR_W-1:0] buf_waddr, buf_raddr;
	logic [tc6rx_pkg::BYTE_W-1:0] buf_rdata;

	// register write never waits
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= tc6rx_pkg::MAX_FRAME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_frame_q <= max_frame_bytes;
		end
	end

	tc6rx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.chunk_first (chunk_first),
		.max_frame_q (max_frame_q),
		.q_full      (q_full),
		.rel         (rel),
		.buf_we      (buf_we),
		.buf_waddr   (buf_waddr),
		.push        (push),
		.push_desc   (push_desc)
	);

	tc6rx_desc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	tc6rx_buf u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (rx_byte),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	tc6rx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.pop           (pop),
		.rel           (rel),
		.buf_re        (buf_re),
		.buf_raddr     (buf_raddr),
		.buf_rdata     (buf_rdata),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_byte     (data_byte),
		.frame_start   (frame_start),
		.frame_end     (frame_end),
		.status        (status),
		.frame_length  (frame_length),
		.last_of_chunk (last_of_chunk)
	);

endmodule
`default_nettype wire

@@ rtl/tc6rx_buf.sv @@
// Two-bank chunk payload buffer: one write port, one registered read port.
// Depends on tc6rx_pkg.
`default_nettype none
module tc6rx_buf (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [tc6rx_pkg::ADDR_W-1:0]  waddr,
	input  wire logic [tc6rx_pkg::BYTE_W-1:0]  wdata,
	input  wire logic                          re,
	input  wire logic [tc6rx_pkg::ADDR_W-1:0]  raddr,
	output logic      [tc6rx_pkg::BYTE_W-1:0]  rdata
);

	logic [tc6rx_pkg::BYTE_W-1:0] mem [tc6rx_pkg::BUF_DEPTH];
	logic [tc6rx_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/tc6rx_desc_fifo.sv @@
// Short descriptor queue between the front end and the back end.
// Depends on tc6rx_pkg.
`default_nettype none
module tc6rx_desc_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire tc6rx_pkg::desc_t push_desc,
	input  wire logic             pop,
	output tc6rx_pkg::desc_t      head,
	output logic                  empty,
	output logic                  full
);

	tc6rx_pkg::desc_t                slot_q [tc6rx_pkg::QDEPTH];
	logic [tc6rx_pkg::QPTR_W-1:0]    wptr_q;
	logic [tc6rx_pkg::QPTR_W-1:0]    rptr_q;
	logic [tc6rx_pkg::QCNT_W-1:0]    cnt_q;

	function automatic logic [tc6rx_pkg::QPTR_W-1:0] ptr_next(
		input logic [tc6rx_pkg::QPTR_W-1:0] p
	);
		return (p == tc6rx_pkg::QPTR_W'(tc6rx_pkg::QDEPTH - 1)) ?
			'0 : p + 1'b1;
	endfunction

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == tc6rx_pkg::QCNT_W'(tc6rx_pkg::QDEPTH));
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_next(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_next(rptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/tc6rx_front.sv @@
// Front end: byte position, payload writes, footer collection and chunk
// classification against the frame state. Depends on tc6rx_pkg.
`default_nettype none
module tc6rx_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [tc6rx_pkg::BYTE_W-1:0]  rx_byte,
	input  wire logic                          chunk_first,
	input  wire logic [tc6rx_pkg::CFG_W-1:0]   max_frame_q,
	input  wire logic                          q_full,
	input  wire tc6rx_pkg::release_t           rel,
	output logic                               buf_we,
	output logic      [tc6rx_pkg::ADDR_W-1:0]  buf_waddr,
	output logic                               push,
	output tc6rx_pkg::desc_t                   push_desc
);

	logic [tc6rx_pkg::POS_W-1:0]  pos_q;
	logic [23:0]                  footer_q;
	logic [tc6rx_pkg::LEN_W-1:0]  frame_q;
	logic                         wbank_q;
	logic [1:0]                   busy_q;

	logic                            accept;
	logic [tc6rx_pkg::POS_W-1:0]     pos;
	logic                            is_payload;
	logic                            is_footer;
	logic [tc6rx_pkg::FOOTER_W-1:0]  footer;
	logic [tc6rx_pkg::CMP_W-1:0]     limit;
	logic                            over;
	logic                            dv, sv, ev;
	logic [tc6rx_pkg::EBO_W:0]       n_full;
	logic [tc6rx_pkg::CNT_W-1:0]     n;
	logic [tc6rx_pkg::LEN_W-1:0]     total;
	tc6rx_pkg::status_t              st;
	logic [1:0]                      busy_set;
	logic [1:0]                      busy_clr;

	// hold input while the bank to be filled is still draining, or no queue room
	assign in_stall = busy_q[wbank_q] || q_full;
	assign accept   = in_valid && !in_stall;

	assign pos        = chunk_first ? '0 : pos_q;
	assign is_payload = (pos < tc6rx_pkg::POS_W'(tc6rx_pkg::CHUNK_BYTES));
	assign is_footer  = !is_payload && (pos < tc6rx_pkg::POS_W'(tc6rx_pkg::CHUNK_BYTES + 3));

	assign buf_we    = accept && is_payload;
	assign buf_waddr = {wbank_q, pos[tc6rx_pkg::CHUNK_W-1:0]};

	assign footer = {footer_q, rx_byte};
	assign dv     = footer[tc6rx_pkg::FTR_DV];
	assign sv     = footer[tc6rx_pkg::FTR_SV];
	assign ev     = footer[tc6rx_pkg::FTR_EV];
	assign n_full = {1'b0, footer[tc6rx_pkg::FTR_EBO +: tc6rx_pkg::EBO_W]} + 1'b1;

	always_comb begin
		if (!ev) begin
			n = tc6rx_pkg::CNT_W'(tc6rx_pkg::CHUNK_BYTES);
		end else if (n_full > (tc6rx_pkg::EBO_W + 1)'(tc6rx_pkg::CHUNK_BYTES)) begin
			n = tc6rx_pkg::CNT_W'(tc6rx_pkg::CHUNK_BYTES);
		end else begin
			n = tc6rx_pkg::CNT_W'(n_full);
		end
	end

	assign total = frame_q + tc6rx_pkg::LEN_W'(n);

	always_comb begin
		if (max_frame_q > tc6rx_pkg::CFG_W'(tc6rx_pkg::MAX_FRAME_LIMIT)) begin
			limit = tc6rx_pkg::CMP_W'(tc6rx_pkg::MAX_FRAME_LIMIT);
		end else begin
			limit = tc6rx_pkg::CMP_W'(max_frame_q);
		end
	end

	assign over = (tc6rx_pkg::CMP_W'(frame_q) + tc6rx_pkg::CMP_W'(tc6rx_pkg::CHUNK_BYTES)) > limit;

	// checks in order: overflow, no valid data, start flag
	always_comb begin
		priority if (over) begin
			st = tc6rx_pkg::ST_OVER;
		end else if (!dv) begin
			st = tc6rx_pkg::ST_EMPTY;
		end else if ((frame_q == '0) != sv) begin
			st = tc6rx_pkg::ST_START;
		end else begin
			st = tc6rx_pkg::ST_DATA;
		end
	end

	assign push = accept && !is_payload && !is_footer;

	// bank held from a data push until the back end has read its last byte
	assign busy_set = (push && (st == tc6rx_pkg::ST_DATA)) ? (2'b01 << wbank_q) : 2'b00;
	assign busy_clr = rel.valid ? (2'b01 << rel.bank) : 2'b00;

	always_comb begin
		push_desc.status   = st;
		push_desc.bank     = wbank_q;
		push_desc.last_idx = (st == tc6rx_pkg::ST_DATA) ?
			tc6rx_pkg::CHUNK_W'(n - 1'b1) : '0;
		push_desc.first    = (frame_q == '0);
		push_desc.ev       = ev;
		push_desc.total    = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			footer_q <= '0;
			frame_q  <= '0;
			wbank_q  <= 1'b0;
			busy_q   <= '0;
		end else begin
			busy_q <= (busy_q & ~busy_clr) | busy_set;
			if (accept) begin
				if (is_payload) begin
					pos_q <= pos + 1'b1;
				end else if (is_footer) begin
					pos_q    <= pos + 1'b1;
					footer_q <= {footer_q[15:0], rx_byte};
				end else begin
					pos_q    <= '0;
					footer_q <= '0;
					if (st == tc6rx_pkg::ST_DATA) begin
						frame_q <= ev ? '0 : total;
						wbank_q <= !wbank_q;
					end else begin
						frame_q <= '0;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/tc6rx_back.sv @@
// Back end: walks the head descriptor, reads buffered bytes and drives the
// output register. Depends on tc6rx_pkg.
`default_nettype none
module tc6rx_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tc6rx_pkg::desc_t              head,
	input  wire logic                          q_empty,
	output logic                               pop,
	output tc6rx_pkg::release_t                rel,
	output logic                               buf_re,
	output logic      [tc6rx_pkg::ADDR_W-1:0]  buf_raddr,
	input  wire logic [tc6rx_pkg::BYTE_W-1:0]  buf_rdata,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [tc6rx_pkg::BYTE_W-1:0]  data_byte,
	output logic                               frame_start,
	output logic                               frame_end,
	output logic      [1:0]                    status,
	output logic      [tc6rx_pkg::LEN_W-1:0]   frame_length,
	output logic                               last_of_chunk
);

	logic [tc6rx_pkg::CHUNK_W-1:0] idx_q;
	logic                          out_valid_q;
	logic                          start_q, end_q, last_q;
	tc6rx_pkg::status_t            status_q;
	logic [tc6rx_pkg::LEN_W-1:0]   len_q;

	logic load;
	logic last;
	logic is_data;

	assign load    = !q_empty && (!out_valid_q || !out_stall);
	assign last    = (idx_q == head.last_idx);
	assign is_data = (head.status == tc6rx_pkg::ST_DATA);
	assign pop     = load && last;

	assign rel.valid = pop && is_data;
	assign rel.bank  = head.bank;

	assign buf_re    = load;
	assign buf_raddr = {head.bank, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= head.status;
			start_q  <= is_data && head.first && (idx_q == '0);
			end_q    <= is_data && head.ev && last;
			len_q    <= (is_data && head.ev && last) ? head.total : '0;
			last_q   <= last;
		end
	end

	assign out_valid     = out_valid_q;
	assign data_byte     = (status_q == tc6rx_pkg::ST_DATA) ? buf_rdata : '0;
	assign frame_start   = start_q;
	assign frame_end     = end_q;
	assign status        = status_q;
	assign frame_length  = len_q;
	assign last_of_chunk = last_q;

endmodule
`default_nettype wire

@@ rtl/tc6rx_checker.sv @@
// Port-level checks for the receive chunk deframer, bound to the top level.
// Depends on tc6rx_pkg and tc6_rx_chunk_deframer_unit.
`default_nettype none
module tc6rx_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [tc6rx_pkg::BYTE_W-1:0]  data_byte,
	input wire logic                          frame_start,
	input wire logic                          frame_end,
	input wire logic [1:0]                    status,
	input wire logic [tc6rx_pkg::LEN_W-1:0]   frame_length,
	input wire logic                          last_of_chunk
);

	// status-only results carry the code and last_of_chunk, nothing else
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != tc6rx_pkg::ST_DATA) |->
		(last_of_chunk && !frame_start && !frame_end &&
		 frame_length == '0 && data_byte == '0))
		else $error("status-only result carries payload marks");

	// a frame only ends on the last byte of a chunk
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> last_of_chunk)
		else $error("frame end not on last byte of chunk");

	// length is reported only with frame end, and is never zero there
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_end ? (frame_length != '0) : (frame_length == '0)))
		else $error("frame length out of place");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(data_byte) && $stable(status) && $stable(last_of_chunk)))
		else $error("stalled result changed");

endmodule

bind tc6_rx_chunk_deframer_unit tc6rx_checker u_chk (.*);
`default_nettype wire

@@ dv/tc6_rx_deframe_checker.sv @@
// Result checker for the receive chunk deframer: watches the link, result and
// configuration channels, predicts every result and compares in order.
// Depends on tc6rx_pkg.
module tc6_rx_deframe_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [tc6rx_pkg::BYTE_W-1:0]  rx_byte,
	input  logic                          chunk_first,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [tc6rx_pkg::BYTE_W-1:0]  data_byte,
	input  logic                          frame_start,
	input  logic                          frame_end,
	input  logic [1:0]                    status,
	input  logic [tc6rx_pkg::LEN_W-1:0]   frame_length,
	input  logic                          last_of_chunk,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [tc6rx_pkg::CFG_W-1:0]   max_frame_bytes,
	output int                            mismatches,
	output int                            outstanding,
	output int                            link_bytes,
	output int                            chunks_closed,
	output int                            results_checked,
	output int                            frames_closed,
	output int                            over_rejects,
	output int                            empty_rejects,
	output int                            start_rejects
);
	import tc6rx_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              frame_start;
		logic              frame_end;
		status_t           status;
		logic [LEN_W-1:0]  frame_length;
		logic              last_of_chunk;
	} frame_result_t;

	frame_result_t     due_results[$];
	logic [BYTE_W-1:0] payload [CHUNK_BYTES];
	logic [POS_W-1:0]  byte_pos   = '0;
	logic [23:0]       footer_acc = '0;
	logic [LEN_W-1:0]  open_bytes = '0;	// zero: no frame open
	logic [CFG_W-1:0]  limit_reg  = MAX_FRAME_RESET;

	function automatic string show(input frame_result_t r);
		return $sformatf("byte %02h start %b end %b status %0d len %0d last %b",
			r.data_byte, r.frame_start, r.frame_end, r.status, r.frame_length,
			r.last_of_chunk);
	endfunction

	task automatic note_fail(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("deframer check: %s", what);
		end
	endtask

	task automatic reject_chunk(input status_t why);
		frame_result_t r;
		r = '0;
		r.status = why;
		r.last_of_chunk = 1'b1;
		due_results.push_back(r);
		open_bytes = '0;
		case (why)
			ST_OVER:  over_rejects++;
			ST_EMPTY: empty_rejects++;
			default:  start_rejects++;
		endcase
	endtask

	task automatic close_chunk(input logic [FOOTER_W-1:0] ftr);
		int               lim;
		int               n;
		logic             ev;
		logic [LEN_W-1:0] total;
		frame_result_t    r;
		lim = (int'(limit_reg) > MAX_FRAME_LIMIT) ? MAX_FRAME_LIMIT : int'(limit_reg);
		ev = ftr[FTR_EV];
		chunks_closed++;
		// overflow outranks an empty chunk, which outranks a start-flag fault
		if (int'(open_bytes) + CHUNK_BYTES > lim) begin
			reject_chunk(ST_OVER);
		end else if (!ftr[FTR_DV]) begin
			reject_chunk(ST_EMPTY);
		end else if (ftr[FTR_SV] == (open_bytes != '0)) begin
			reject_chunk(ST_START);
		end else begin
			n = ev ? int'(ftr[FTR_EBO +: EBO_W]) + 1 : CHUNK_BYTES;
			if (n > CHUNK_BYTES) begin
				n = CHUNK_BYTES;
			end
			total = LEN_W'(int'(open_bytes) + n);
			for (int i = 0; i < n; i++) begin
				r.data_byte     = payload[i];
				r.frame_start   = (i == 0) && (open_bytes == '0);
				r.frame_end     = (i == n - 1) && ev;
				r.status        = ST_DATA;
				r.frame_length  = r.frame_end ? total : '0;
				r.last_of_chunk = (i == n - 1);
				due_results.push_back(r);
			end
			if (ev) begin
				frames_closed++;
			end
			open_bytes = ev ? '0 : total;
		end
	endtask

	task automatic take_link_byte(input logic [BYTE_W-1:0] b, input logic first);
		if (first) begin
			byte_pos = '0;
		end
		if (byte_pos < POS_W'(CHUNK_BYTES)) begin
			payload[byte_pos[CHUNK_W-1:0]] = b;
			byte_pos = byte_pos + 1'b1;
		end else if (byte_pos < POS_W'(CHUNK_BYTES + 3)) begin
			footer_acc = {footer_acc[15:0], b};
			byte_pos = byte_pos + 1'b1;
		end else begin
			byte_pos = '0;
			close_chunk({footer_acc, b});
			footer_acc = '0;
		end
	endtask

	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (!arst_n) begin
			due_results.delete();
			byte_pos   = '0;
			footer_acc = '0;
			open_bytes = '0;
			limit_reg  = MAX_FRAME_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_reg = max_frame_bytes;
			end
			if (out_valid && !out_stall) begin
				got.data_byte     = data_byte;
				got.frame_start   = frame_start;
				got.frame_end     = frame_end;
				got.status        = status_t'(status);
				got.frame_length  = frame_length;
				got.last_of_chunk = last_of_chunk;
				results_checked++;
				if (due_results.size() == 0) begin
					note_fail({"unexpected result ", show(got)});
				end else begin
					want = due_results.pop_front();
					if (got.data_byte !== want.data_byte
							|| got.frame_start !== want.frame_start
							|| got.frame_end !== want.frame_end
							|| got.status !== want.status
							|| got.frame_length !== want.frame_length
							|| got.last_of_chunk !== want.last_of_chunk) begin
						note_fail($sformatf("result %0d: expected %s, got %s",
							results_checked, show(want), show(got)));
					end
				end
			end
			if (in_valid && !in_stall) begin
				link_bytes++;
				take_link_byte(rx_byte, chunk_first);
			end
		end
		outstanding = due_results.size();
	end

endmodule

@@ dv/tc6_rx_chunk_deframer_unit_test.sv @@
// Top of the receive chunk deframer testbench: clock, reset, link byte and
// configuration stimulus, receiver stall pattern and the verdict.
// Depends on tc6rx_pkg, tc6_rx_chunk_deframer_unit and tc6_rx_deframe_checker.
module tc6_rx_chunk_deframer_unit_test;
	import tc6rx_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;	// far beyond the slowest legal run
	localparam int SETTLE_CYCLES = 8;	// front end to output passes the queue and output registers
	localparam int END_CYCLES    = 50;
	localparam int HOLD_CYCLES   = 400;	// long enough to fill both banks and the queue

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_RAMP} fill_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	// block inputs, all known from time zero
	logic              clk             = 1'b0;
	logic              arst_n          = 1'b0;
	logic              in_valid        = 1'b0;
	logic [BYTE_W-1:0] rx_byte         = '0;
	logic              chunk_first     = 1'b0;
	logic              out_stall       = 1'b0;
	logic              cfg_valid       = 1'b0;
	logic [CFG_W-1:0]  max_frame_bytes = MAX_FRAME_RESET;

	// block outputs
	logic              in_stall;
	logic              out_valid;
	logic [BYTE_W-1:0] data_byte;
	logic              frame_start;
	logic              frame_end;
	logic [1:0]        status;
	logic [LEN_W-1:0]  frame_length;
	logic              last_of_chunk;
	logic              cfg_ready;

	// figures handed up by the checker
	int mismatches;
	int outstanding;
	int link_bytes;
	int chunks_closed;
	int results_checked;
	int frames_closed;
	int over_rejects;
	int empty_rejects;
	int start_rejects;

	int cycle_count  = 0;
	int limit_writes = 0;
	int hold_ticket  = 0;	// bumped by the stimulus to ask for one long hold-off
	bit aligned      = 1'b1;	// last thing sent was a whole chunk
	bit steady       = 1'b0;	// sender offers back to back, no gaps
	int burst_left   = 0;

	// receiver pattern state, owned by the stall process alone
	int          hold_served  = 0;
	int          hold_left    = 0;
	int          mode_left    = 0;
	int          stall_period = 2;
	stall_mode_t stall_mode   = STALL_NONE;

	always #5 clk = ~clk;

	tc6_rx_chunk_deframer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.chunk_first    (chunk_first),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_byte      (data_byte),
		.frame_start    (frame_start),
		.frame_end      (frame_end),
		.status         (status),
		.frame_length   (frame_length),
		.last_of_chunk  (last_of_chunk),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.max_frame_bytes(max_frame_bytes)
	);

	tc6_rx_deframe_checker deframe_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.chunk_first    (chunk_first),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_byte      (data_byte),
		.frame_start    (frame_start),
		.frame_end      (frame_end),
		.status         (status),
		.frame_length   (frame_length),
		.last_of_chunk  (last_of_chunk),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.max_frame_bytes(max_frame_bytes),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.link_bytes     (link_bytes),
		.chunks_closed  (chunks_closed),
		.results_checked(results_checked),
		.frames_closed  (frames_closed),
		.over_rejects   (over_rejects),
		.empty_rejects  (empty_rejects),
		.start_rejects  (start_rejects)
	);

	// Receiver side. A long hold-off, when asked for, takes priority; otherwise
	// the pattern switches to a random mode when the current one runs out, so stalls
	// land on every phase of a chunk's drain, with clean stretches in between.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_served != hold_ticket) begin
			hold_served = hold_ticket;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(32, 256);
				stall_period = $urandom_range(2, 7);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= (mode_left % stall_period == 0);
			endcase
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped after %0d cycles, %0d results outstanding",
			cycle_count, outstanding);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// One link byte transaction. Values change on the falling edge and the
	// transaction completes at the first rising edge with in_stall low; the byte
	// stays put while stalled. In bursty mode a random gap opens between bursts.
	task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic first);
		if (!steady && burst_left == 0) begin
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				in_valid    <= 1'b0;
				rx_byte     <= BYTE_W'($urandom);
				chunk_first <= 1'($urandom);
			end
			burst_left = $urandom_range(1, 48);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		rx_byte     <= b;
		chunk_first <= first;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Footer with the used fields set and every other bit (parity included) random.
	function automatic logic [FOOTER_W-1:0] make_footer(input logic dv, input logic sv,
			input logic ev, input logic [EBO_W-1:0] ebo);
		logic [FOOTER_W-1:0] f;
		f = FOOTER_W'($urandom);
		f[FTR_DV] = dv;
		f[FTR_SV] = sv;
		f[FTR_EV] = ev;
		f[FTR_EBO +: EBO_W] = ebo;
		return f;
	endfunction

	// Whole chunk: payload then footer MSB first. The start mark may be left off
	// only when the position has wrapped to zero by itself.
	task automatic send_chunk(input logic [FOOTER_W-1:0] ftr, input fill_t fill,
			input logic mark);
		logic [BYTE_W-1:0] b;
		for (int i = 0; i < CHUNK_BYTES; i++) begin
			case (fill)
				FILL_ZERO: b = '0;
				FILL_ONES: b = '1;
				FILL_RAMP: b = BYTE_W'(i);
				default:   b = BYTE_W'($urandom);
			endcase
			offer_byte(b, (i == 0) ? (mark || !aligned) : 1'b0);
		end
		for (int i = 3; i >= 0; i--) begin
			offer_byte(ftr[8*i +: 8], 1'b0);
		end
		aligned = 1'b1;
	endtask

	// Chunk cut short; the next chunk's start mark realigns the block.
	task automatic send_partial(input int n);
		for (int i = 0; i < n; i++) begin
			offer_byte(BYTE_W'($urandom), i == 0);
		end
		aligned = 1'b0;
	endtask

	// Well-formed frame: SV on the first chunk, EV with the given EBO on the last.
	task automatic send_frame(input int chunks, input logic [EBO_W-1:0] ebo);
		for (int k = 0; k < chunks; k++) begin
			send_chunk(make_footer(1'b1, k == 0, k == chunks - 1, ebo), FILL_RANDOM,
				$urandom_range(0, 3) != 0);
		end
	endtask

	// Stop offering until every predicted result has come out, then let the
	// block settle for the given number of extra cycles in case a trailing byte is still in flight.
	task automatic drain(input int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (extra) begin
			@(negedge clk);
		end
	endtask

	// Register write transaction, only ever issued with the block idle.
	task automatic write_limit(input logic [CFG_W-1:0] v);
		drain(SETTLE_CYCLES);
		@(negedge clk);
		cfg_valid       <= 1'b1;
		max_frame_bytes <= v;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		limit_writes++;
	endtask

	// Mostly well-formed frames of random length and content; the rest is
	// truncated chunks and chunks with random flag bits.
	task automatic random_traffic(input int target);
		int sent;
		int pick;
		int len;
		logic [EBO_W-1:0] ebo;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
				ebo = ($urandom_range(0, 7) == 0) ? '1 : EBO_W'($urandom);
				send_frame(len, ebo);
				sent += len;
			end else if (pick < 82) begin
				send_partial($urandom_range(1, CHUNK_BYTES + 3));
			end else begin
				send_chunk(make_footer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), EBO_W'($urandom)), FILL_RANDOM,
					$urandom_range(0, 3) != 0);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (11) begin
			@(negedge clk);
		end
		arst_n <= 1'b1;

		// --- directed, limit at its reset value ---
		send_chunk(make_footer(1'b1, 1'b1, 1'b1, 6'd0), FILL_ZERO, 1'b1);	// one-byte frame
		send_chunk(make_footer(1'b1, 1'b1, 1'b1, 6'd63), FILL_ONES, 1'b1);	// full chunk frame
		// three-chunk frame, first one relying on the position wrap
		send_chunk(make_footer(1'b1, 1'b1, 1'b0, 6'd0), FILL_RAMP, 1'b0);
		send_chunk(make_footer(1'b1, 1'b0, 1'b0, 6'd0), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b1, 1'b0, 1'b1, 6'd10), FILL_RANDOM, 1'b1);
		// empty chunk with no frame open, then in the middle of a frame
		send_chunk(make_footer(1'b0, 1'b1, 1'b1, 6'd5), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b1, 1'b1, 1'b0, 6'd0), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b0, 1'b0, 1'b0, 6'd0), FILL_RANDOM, 1'b1);
		// start flag missing with nothing open, then repeated inside a frame
		send_chunk(make_footer(1'b1, 1'b0, 1'b1, 6'd3), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b1, 1'b1, 1'b0, 6'd0), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b1, 1'b1, 1'b1, 6'd7), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b1, 1'b0, 1'b1, 6'd7), FILL_RANDOM, 1'b1);	// frame was dropped
		// realign mid payload, mid footer and one byte short of the end
		send_partial(20);
		send_chunk(make_footer(1'b1, 1'b1, 1'b1, 6'd30), FILL_RANDOM, 1'b1);
		send_partial(CHUNK_BYTES + 2);
		send_chunk(make_footer(1'b1, 1'b1, 1'b1, 6'd63), FILL_RANDOM, 1'b1);
		send_partial(CHUNK_BYTES + 3);
		send_chunk(make_footer(1'b1, 1'b1, 1'b1, 6'd1), FILL_RANDOM, 1'b1);

		// smallest limit: one chunk per frame, anything longer overflows
		write_limit(CFG_W'(64));
		send_chunk(make_footer(1'b1, 1'b1, 1'b0, 6'd0), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b1, 1'b0, 1'b1, 6'd0), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b1, 1'b1, 1'b1, 6'd63), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b1, 1'b1, 1'b0, 6'd0), FILL_RANDOM, 1'b1);
		send_chunk(make_footer(1'b0, 1'b0, 1'b0, 6'd0), FILL_RANDOM, 1'b1);	// overflow wins
		send_chunk(make_footer(1'b1, 1'b0, 1'b1, 6'd0), FILL_RANDOM, 1'b1);

		// --- random ---
		// back-to-back sender against one long receiver hold-off: banks fill
		// and the input has to stall
		write_limit(CFG_W'($urandom_range(64, 2048)));
		steady = 1'b1;
		hold_ticket++;
		random_traffic(15);
		steady = 1'b0;
		drain(0);

		write_limit(CFG_W'(64));
		random_traffic(8);

		// largest limit: a frame ending exactly at it, then one that runs past
		write_limit(CFG_W'(MAX_FRAME_LIMIT));
		send_frame(MAX_FRAME_LIMIT / CHUNK_BYTES, '1);
		send_frame(MAX_FRAME_LIMIT / CHUNK_BYTES + 1, EBO_W'($urandom));
		random_traffic(6);

		write_limit(CFG_W'($urandom_range(128, 512)));
		random_traffic(12);

		drain(END_CYCLES);

		$display("covered %0d link bytes in %0d chunks, %0d results checked, %0d frames closed",
			link_bytes, chunks_closed, results_checked, frames_closed);
		$display("rejects: %0d overflow, %0d empty, %0d start flag; %0d limit writes, %0d hold-offs",
			over_rejects, empty_rejects, start_rejects, limit_writes, hold_ticket);
		if (outstanding != 0) begin
			$display("%0d predicted results never arrived", outstanding);
		end
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
